FILE: design/drs_pkg.sv
// Shared types and constants for the disk request scheduler.
// Depends on nothing; every design file refers to it by scoped names.
`default_nettype none

package drs_pkg;

	localparam int QUEUE_DEPTH = 16;

	localparam int ID_W     = 16;
	localparam int STAMP_W  = 32;
	localparam int CYL_W    = 16;
	localparam int ADDR_W   = 32;
	localparam int PROC_W   = 16;
	localparam int PEND_W   = 5;
	localparam int POLICY_W = 2;

	// selection policy codes; the unused code behaves as first-come-first-served
	localparam logic [POLICY_W-1:0] POL_FCFS = 2'd0;
	localparam logic [POLICY_W-1:0] POL_SSTF = 2'd1;
	localparam logic [POLICY_W-1:0] POL_LOOK = 2'd2;

	// input transaction kinds
	localparam logic KIND_ARRIVE   = 1'b0;
	localparam logic KIND_COMPLETE = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [STAMP_W-1:0] stamp;
		logic [CYL_W-1:0]   cyl;
		logic [ADDR_W-1:0]  addr;
		logic [PROC_W-1:0]  proc;
	} entry_t;

	typedef struct packed {
		logic               kind;
		logic [ID_W-1:0]    req_tag;
		logic [STAMP_W-1:0] arrival_time;
		logic [CYL_W-1:0]   cylinder;
		logic [ADDR_W-1:0]  block_address;
		logic [PROC_W-1:0]  owner_process;
		logic [CYL_W-1:0]   head_cylinder;
		logic               scan_up;
	} item_t;

	typedef struct packed {
		logic               served_valid;
		logic [ID_W-1:0]    served_id;
		logic [STAMP_W-1:0] served_time;
		logic [CYL_W-1:0]   served_cylinder;
		logic [ADDR_W-1:0]  served_address;
		logic [PROC_W-1:0]  served_process;
		logic [PEND_W-1:0]  pending_count;
		logic               dropped;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic arrive;     // apply an arrival
		logic go_idle;    // completion with nothing queued
		logic scan_init;  // capture head and direction, rewind pointer
		logic scan_read;  // read queue entry at pointer for selection
		logic move_init;  // point just past the picked entry
		logic move_read;  // read entry at pointer to shift it down one place
		logic commit;     // picked entry goes into service
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic count_zero;
		logic scan_last;
		logic move_none;
		logic move_last;
	} stat_t;

endpackage

`default_nettype wire

FILE: design/disk_request_scheduler.sv
// Top level of the disk request scheduler: controller plus datapath.
// Depends on drs_pkg, drs_ctrl and drs_dpath.
//
//   channel   signals                      transfer
//   -------   --------------------------   ---------------------------------
//   input     start, busy, item            start high and busy low at an edge
//   result    done, result                 done high for one cycle, no stall
//   config    cfg_valid, cfg_ready, cfg_data  valid and ready high at an edge
//
// An arrival, or a completion with an empty queue, gives its result in the
// cycle after acceptance. A completion with queued entries runs a selection
// scan over every queued entry for SSTF and LOOK, and over the head entry
// otherwise, then compacts the entries behind the picked one and commits it;
// the single read port of the queue memory reads one entry per cycle for the
// selection scan and one per cycle for compaction. busy stays high until the
// strobe. After reset the block is idle with an empty queue and the policy
// register at first-come-first-served. Results cannot be held off.
`default_nettype none

module disk_request_scheduler #(
	parameter int QUEUE_DEPTH = drs_pkg::QUEUE_DEPTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire drs_pkg::item_t               item,
	output logic                              done,
	output drs_pkg::result_t                  result,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [drs_pkg::POLICY_W-1:0] cfg_data
);

	drs_pkg::cmd_t  cmd;
	drs_pkg::stat_t stat;

	// the policy register is always writable
	assign cfg_ready = 1'b1;

	drs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	drs_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule

`default_nettype wire

FILE: design/drs_dpath.sv
// Datapath of the disk request scheduler: queue memory, service registers,
// selection comparator and compaction. Depends on drs_pkg; driven by drs_ctrl.
`default_nettype none

module drs_dpath #(
	parameter int QUEUE_DEPTH = drs_pkg::QUEUE_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire drs_pkg::item_t                  item,
	input  wire logic                            cfg_valid,
	input  wire logic [drs_pkg::POLICY_W-1:0]    cfg_data,
	input  wire drs_pkg::cmd_t                   cmd,
	output drs_pkg::stat_t                       stat,
	output drs_pkg::result_t                     result
);

	localparam int IW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int PADW = CW + drs_pkg::PEND_W;
	localparam int DW   = drs_pkg::CYL_W + 1;

	drs_pkg::entry_t mem [QUEUE_DEPTH];

	logic [drs_pkg::POLICY_W-1:0] policy_q;
	logic                         busy_q;
	logic                         dropped_q;
	logic [CW-1:0]                count_q;
	drs_pkg::entry_t              serving_q;
	logic [drs_pkg::CYL_W-1:0]    head_q;
	logic                         up_q;
	logic [CW-1:0]                ptr_q;
	drs_pkg::entry_t              best_q;
	logic [IW-1:0]                best_idx_q;
	drs_pkg::entry_t              rdata_q;
	logic [IW-1:0]                ridx_q;
	logic                         rvalid_q;
	logic                         rmove_q;

	drs_pkg::entry_t new_entry;
	drs_pkg::entry_t wdata;
	logic [IW-1:0]   waddr;
	logic            we;
	logic            rd_en;
	logic            full;
	logic            enqueue;
	logic            scan_wide;
	logic [CW-1:0]   scan_limit;
	logic [CW-1:0]   ptr_next;
	logic [CW-1:0]   best_next;
	logic [PADW-1:0] count_pad;
	logic [DW-1:0]   d;
	logic [DW-1:0]   m;
	logic [DW-1:0]   ad;
	logic [DW-1:0]   am;
	logic            d_neg;
	logic            m_neg;
	logic            d_zero;
	logic            m_zero;
	logic            same_side;
	logic            wrong_side;
	logic            take_new;

	assign new_entry = '{id: item.req_tag, stamp: item.arrival_time,
		cyl: item.cylinder, addr: item.block_address, proc: item.owner_process};

	assign full    = (count_q == CW'(QUEUE_DEPTH));
	assign enqueue = cmd.arrive && busy_q && !full;

	// FCFS and the unused code only ever look at the head entry
	assign scan_wide  = (policy_q == drs_pkg::POL_SSTF) || (policy_q == drs_pkg::POL_LOOK);
	assign scan_limit = scan_wide ? count_q : CW'(1);
	assign ptr_next   = ptr_q + CW'(1);
	assign best_next  = CW'(best_idx_q) + CW'(1);

	assign stat = '{
		count_zero: (count_q == '0),
		scan_last:  (ptr_next >= scan_limit),
		move_none:  (best_next >= count_q),
		move_last:  (ptr_next >= count_q)
	};

	always_comb begin
		we    = 1'b0;
		waddr = count_q[IW-1:0];
		wdata = new_entry;
		if (enqueue) begin
			we = 1'b1;
		end else if (rvalid_q && rmove_q) begin
			we    = 1'b1;
			waddr = ridx_q - IW'(1);
			wdata = rdata_q;
		end
	end

	assign rd_en = cmd.scan_read || cmd.move_read;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[ptr_q[IW-1:0]];
			ridx_q  <= ptr_q[IW-1:0];
		end
	end

	// signed offsets from the head, for the entry just read and for the best so far
	assign d      = {1'b0, rdata_q.cyl} - {1'b0, head_q};
	assign m      = {1'b0, best_q.cyl} - {1'b0, head_q};
	assign d_neg  = d[DW-1];
	assign m_neg  = m[DW-1];
	assign d_zero = (d == '0);
	assign m_zero = (m == '0);
	assign ad     = d_neg ? (~d + DW'(1)) : d;
	assign am     = m_neg ? (~m + DW'(1)) : m;

	assign same_side  = d_zero || m_zero || (d_neg == m_neg);
	assign wrong_side = up_q ? m_neg : (!m_neg && !m_zero);

	always_comb begin
		take_new = 1'b0;
		if (policy_q == drs_pkg::POL_SSTF) begin
			take_new = (ad < am);
		end else if (policy_q == drs_pkg::POL_LOOK) begin
			if (same_side) begin
				take_new = (ad < am) || ((ad == am) && (rdata_q.stamp < best_q.stamp));
			end else begin
				take_new = wrong_side;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rvalid_q && !rmove_q && ((ridx_q == '0) || take_new)) begin
			best_q     <= rdata_q;
			best_idx_q <= ridx_q;
		end
		if (cmd.scan_init) begin
			head_q <= item.head_cylinder;
			up_q   <= item.scan_up;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= drs_pkg::POL_FCFS;
			busy_q    <= 1'b0;
			dropped_q <= 1'b0;
			count_q   <= '0;
			serving_q <= '0;
			ptr_q     <= '0;
			rvalid_q  <= 1'b0;
			rmove_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				policy_q <= cfg_data;
			end
			rvalid_q <= rd_en;
			rmove_q  <= cmd.move_read;
			if (cmd.scan_init) begin
				ptr_q <= '0;
			end else if (cmd.move_init) begin
				ptr_q <= best_next;
			end else if (rd_en) begin
				ptr_q <= ptr_next;
			end
			if (cmd.arrive) begin
				dropped_q <= busy_q && full;
				if (!busy_q) begin
					busy_q    <= 1'b1;
					serving_q <= new_entry;
				end else if (!full) begin
					count_q <= count_q + CW'(1);
				end
			end else if (cmd.go_idle) begin
				dropped_q <= 1'b0;
				busy_q    <= 1'b0;
				serving_q <= '0;
			end else if (cmd.commit) begin
				dropped_q <= 1'b0;
				busy_q    <= 1'b1;
				serving_q <= best_q;
				count_q   <= count_q - CW'(1);
			end
		end
	end

	assign count_pad = PADW'(count_q);

	assign result = '{
		served_valid:    busy_q,
		served_id:       serving_q.id,
		served_time:     serving_q.stamp,
		served_cylinder: serving_q.cyl,
		served_address:  serving_q.addr,
		served_process:  serving_q.proc,
		pending_count:   count_pad[drs_pkg::PEND_W-1:0],
		dropped:         dropped_q
	};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_commit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (busy_q && !dropped_q))
		else $error("picked request not in service");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go_idle |=> (!busy_q && (serving_q == '0)))
		else $error("idle with stale service registers");

endmodule

`default_nettype wire

FILE: design/drs_ctrl.sv
// Controller of the disk request scheduler: sequences arrival, selection scan,
// queue compaction and commit. Depends on drs_pkg; drives drs_dpath.
`default_nettype none

module drs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           kind,
	input  wire drs_pkg::stat_t stat,
	output drs_pkg::cmd_t       cmd,
	output logic                busy,
	output logic                done
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_END,
		S_MOVE_CHK,
		S_MOVE,
		S_MOVE_END,
		S_COMMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;
	logic   done_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		done_d  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (kind == drs_pkg::KIND_ARRIVE) begin
						cmd.arrive = 1'b1;
						done_d     = 1'b1;
					end else if (stat.count_zero) begin
						cmd.go_idle = 1'b1;
						done_d      = 1'b1;
					end else begin
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_read = 1'b1;
				if (stat.scan_last) begin
					state_d = S_SCAN_END;
				end
			end
			// last read data is compared in this cycle
			S_SCAN_END: begin
				state_d = S_MOVE_CHK;
			end
			S_MOVE_CHK: begin
				cmd.move_init = 1'b1;
				state_d       = stat.move_none ? S_COMMIT : S_MOVE;
			end
			S_MOVE: begin
				cmd.move_read = 1'b1;
				if (stat.move_last) begin
					state_d = S_MOVE_END;
				end
			end
			// last shifted entry is written in this cycle
			S_MOVE_END: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				done_d     = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while still working");

	a_commit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT) |=> (done_q && (state_q == S_IDLE)))
		else $error("commit without result strobe");

	a_arrive_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == drs_pkg::KIND_ARRIVE)) |=> done_q)
		else $error("arrival without result next cycle");

endmodule

`default_nettype wire
